FILE: rtl/cpt_pkg.sv
// Package for the capture-period tachometer: state encoding, status and
// register-index codes and datapath widths.
// No dependencies; imported by every module of the block.
`default_nettype none

package cpt_pkg;

    // Width of the shared adder/subtractor (65-bit divisor plus shift-in bit).
    localparam int ALU_WIDTH = 66;
    // Quotient and dividend width of the division passes.
    localparam int DIV_STEPS = 44;
    // Multiplier bits consumed by a shift-add multiply pass.
    localparam int MUL_STEPS = 17;
    localparam int CNT_WIDTH = 6;

    // Register indexes on the configuration channel.
    localparam logic [2:0] CFG_TIMER_CLOCK_HZ   = 3'd0;
    localparam logic [2:0] CFG_PRESCALE_DIVISOR = 3'd1;
    localparam logic [2:0] CFG_RELOAD_VALUE     = 3'd2;
    localparam logic [2:0] CFG_PULSES_PER_REV   = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT_MS       = 3'd4;
    localparam logic [2:0] CFG_MIN_INTERVAL     = 3'd5;

    // Result status codes.
    localparam logic [1:0] STATUS_UPDATED   = 2'd0;
    localparam logic [1:0] STATUS_REJECTED  = 2'd1;
    localparam logic [1:0] STATUS_TIMED_OUT = 2'd2;
    localparam logic [1:0] STATUS_UNCHANGED = 2'd3;

    // Input item kinds.
    localparam logic MODE_CAPTURE = 1'b0;
    localparam logic MODE_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CHECK,
        ST_MUL1,
        ST_MUL2,
        ST_DIVF,
        ST_DIVR,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/cpt_addsub.sv
// Shared adder/subtractor of the tachometer datapath.
// Depends on cpt_pkg for its width.
`default_nettype none

module cpt_addsub
    import cpt_pkg::*;
(
    input  wire logic [ALU_WIDTH-1:0] a,
    input  wire logic [ALU_WIDTH-1:0] b,
    input  wire logic                 sub,
    output logic      [ALU_WIDTH:0]   sum   // Top bit is the carry out (no borrow).
);

    logic [ALU_WIDTH-1:0] b_op;

    assign b_op = sub ? ~b : b;
    assign sum  = {1'b0, a} + {1'b0, b_op} + (ALU_WIDTH+1)'(sub);

endmodule

`default_nettype wire

FILE: rtl/capture_period_tachometer.sv
// Capture-period tachometer top level: control sequencer, configuration
// registers and the iterative multiply/divide datapath.
// Depends on cpt_pkg and cpt_addsub.
//
// Usage. Each transaction on the slave stream is a capture event
// (s_tuser = 0) or a timeout check (s_tuser = 1), carrying the captured
// counter value and a millisecond timestamp. Every input transaction gives
// exactly one result transaction on the master stream with the held
// frequency and rpm (unsigned, 8 fraction bits, saturating) and a status.
// Configuration writes come over the cfg channel, which is always ready,
// and are to be made while the block is idle; the block does not enforce this.
// Sequence. A rejected capture or a timeout check goes through the evaluate,
// check and emit states to m_tvalid. An accepted capture also enters the
// datapath: one shared 66-bit adder/subtractor runs two 17-step shift-add
// multiplies (interval times prescaler, then times pulses per revolution)
// and two 44-step restoring divisions, one bit per cycle. s_tready is high
// only while the sequencer is idle, so one item is in work at a time.
// A finished result sits in the output register; the next item is accepted
// while it waits. If the receiver still stalls when the following result is
// ready, the sequencer holds in its final state until the register frees.
// Reset (aresetn low, synchronous) restores the register defaults and clears
// the held capture, timestamp, frequency and rpm.
`default_nettype none

module capture_period_tachometer
    import cpt_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // capture_value [31:0], now_ms [63:32]
    input  wire logic        s_tuser,   // mode [0]
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata,   // frequency_q8 [31:0], speed_rpm_q8 [71:32]
    output logic      [1:0]  m_tuser,   // status [1:0]
    // Configuration write channel.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    // Configuration registers.
    logic [29:0] clock_hz_reg;
    logic [16:0] prescale_reg;
    logic [31:0] reload_reg;
    logic [15:0] ppr_reg;
    logic [31:0] timeout_reg;
    logic [15:0] min_interval_reg;

    // Architectural state.
    logic [COUNTER_WIDTH-1:0] prev_reg, prev_next;
    logic [31:0] last_ms_reg, last_ms_next;
    logic [31:0] held_freq_reg, held_freq_next;
    logic [39:0] held_rpm_reg, held_rpm_next;

    // Sequencer and datapath.
    state_t state_reg, state_next;
    logic                 mode_reg;
    logic [31:0]          cap_reg;
    logic [31:0]          now_reg;
    logic [31:0]          diff_reg, diff_next;
    logic [1:0]           status_reg, status_next;
    logic [ALU_WIDTH-1:0] acc_reg, acc_next;
    logic [64:0]          mcand_reg, mcand_next;
    logic [16:0]          mplier_reg, mplier_next;
    logic [48:0]          den1_reg, den1_next;
    logic [64:0]          den2_reg, den2_next;
    logic [DIV_STEPS-1:0] num_reg, num_next;
    logic [DIV_STEPS-1:0] quot_reg, quot_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [71:0] out_data_reg, out_data_next;
    logic [1:0]  out_user_reg, out_user_next;

    logic s_accept;
    logic out_free;
    logic mul_last;
    logic div_last;

    logic [COUNTER_WIDTH-1:0] cap_c;
    logic [COUNTER_WIDTH-1:0] rel_c;
    logic [COUNTER_WIDTH-1:0] interval;
    logic                     reject;
    logic                     timed_out;
    logic [16:0]              pre_eff;
    logic [16:0]              ppr_eff;
    logic [DIV_STEPS-1:0]     numr;

    logic [ALU_WIDTH-1:0] alu_a;
    logic [ALU_WIDTH-1:0] alu_b;
    logic                 alu_sub;
    logic [ALU_WIDTH:0]   alu_sum;
    logic [ALU_WIDTH-1:0] mul_acc;
    logic [ALU_WIDTH-1:0] div_shifted;
    logic                 div_bit;
    logic [ALU_WIDTH-1:0] div_rem;
    logic [DIV_STEPS-1:0] div_quot;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign mul_last  = (cnt_reg == CNT_WIDTH'(MUL_STEPS - 1));
    assign div_last  = (cnt_reg == CNT_WIDTH'(DIV_STEPS - 1));

    // Interval since the previous capture. When the capture is below the
    // previous one the counter wrapped at the reload value, and one full
    // period of reload + 1 ticks is added; a previous capture above reload
    // simply wraps modulo the counter width.
    assign cap_c    = cap_reg[COUNTER_WIDTH-1:0];
    assign rel_c    = reload_reg[COUNTER_WIDTH-1:0];
    assign interval = ((cap_c >= prev_reg) || (prev_reg > rel_c))
                    ? (cap_c - prev_reg)
                    : (rel_c - prev_reg + cap_c + COUNTER_WIDTH'(1));

    assign reject    = (diff_reg == 32'd0) || (diff_reg < 32'(min_interval_reg));
    assign timed_out = (diff_reg > timeout_reg);
    assign pre_eff   = (prescale_reg == 17'd0) ? 17'd1 : prescale_reg;
    assign ppr_eff   = (ppr_reg == 16'd0) ? 17'd1 : 17'(ppr_reg);
    // clock * 256 * 60 = (clock << 14) - (clock << 10).
    assign numr      = (DIV_STEPS'(clock_hz_reg) << 14) - (DIV_STEPS'(clock_hz_reg) << 10);

    // Shared adder: accumulate in the multiply passes, trial subtract in
    // the division passes.
    assign div_shifted = {acc_reg[ALU_WIDTH-2:0], num_reg[DIV_STEPS-1]};

    always_comb begin
        alu_a   = acc_reg;
        alu_b   = ALU_WIDTH'(mcand_reg);
        alu_sub = 1'b0;
        case (state_reg)
            ST_DIVF: begin
                alu_a   = div_shifted;
                alu_b   = ALU_WIDTH'(den1_reg);
                alu_sub = 1'b1;
            end
            ST_DIVR: begin
                alu_a   = div_shifted;
                alu_b   = ALU_WIDTH'(den2_reg);
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = acc_reg;
                alu_b   = ALU_WIDTH'(mcand_reg);
                alu_sub = 1'b0;
            end
        endcase
    end

    cpt_addsub u_addsub (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum)
    );

    assign mul_acc  = mplier_reg[0] ? alu_sum[ALU_WIDTH-1:0] : acc_reg;
    assign div_bit  = alu_sum[ALU_WIDTH];
    assign div_rem  = div_bit ? alu_sum[ALU_WIDTH-1:0] : div_shifted;
    assign div_quot = {quot_reg[DIV_STEPS-2:0], div_bit};

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_accept) begin
                state_next = ST_EVAL;
            end
            ST_EVAL:  state_next = ST_CHECK;
            ST_CHECK: begin
                if (mode_reg == MODE_TIMEOUT || reject) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:  if (mul_last) begin
                state_next = ST_MUL2;
            end
            ST_MUL2:  if (mul_last) begin
                state_next = ST_DIVF;
            end
            ST_DIVF:  if (div_last) begin
                state_next = ST_DIVR;
            end
            ST_DIVR:  if (div_last) begin
                state_next = ST_EMIT;
            end
            ST_EMIT:  if (out_free) begin
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        prev_next      = prev_reg;
        last_ms_next   = last_ms_reg;
        held_freq_next = held_freq_reg;
        held_rpm_next  = held_rpm_reg;
        diff_next      = diff_reg;
        status_next    = status_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        den1_next      = den1_reg;
        den2_next      = den2_reg;
        num_next       = num_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        case (state_reg)
            ST_EVAL: begin
                if (mode_reg == MODE_TIMEOUT) begin
                    diff_next = now_reg - last_ms_reg;
                end else begin
                    diff_next = 32'(interval);
                    prev_next = cap_c;
                end
            end
            ST_CHECK: begin
                if (mode_reg == MODE_TIMEOUT) begin
                    if (timed_out) begin
                        held_freq_next = 32'd0;
                        held_rpm_next  = 40'd0;
                        status_next    = STATUS_TIMED_OUT;
                    end else begin
                        status_next = STATUS_UNCHANGED;
                    end
                end else if (reject) begin
                    status_next = STATUS_REJECTED;
                end else begin
                    acc_next    = '0;
                    mcand_next  = 65'(diff_reg);
                    mplier_next = pre_eff;
                    cnt_next    = '0;
                end
            end
            ST_MUL1, ST_MUL2: begin
                acc_next    = mul_acc;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + CNT_WIDTH'(1);
                if (mul_last) begin
                    acc_next = '0;
                    cnt_next = '0;
                    if (state_reg == ST_MUL1) begin
                        den1_next   = mul_acc[48:0];
                        mcand_next  = 65'(mul_acc[48:0]);
                        mplier_next = ppr_eff;
                    end else begin
                        den2_next = mul_acc[64:0];
                        num_next  = DIV_STEPS'({clock_hz_reg, 8'd0});
                        quot_next = '0;
                    end
                end
            end
            ST_DIVF, ST_DIVR: begin
                acc_next  = div_rem;
                num_next  = num_reg << 1;
                quot_next = div_quot;
                cnt_next  = cnt_reg + CNT_WIDTH'(1);
                if (div_last) begin
                    acc_next  = '0;
                    cnt_next  = '0;
                    quot_next = '0;
                    if (state_reg == ST_DIVF) begin
                        held_freq_next = (|div_quot[DIV_STEPS-1:32]) ? '1 : div_quot[31:0];
                        num_next       = numr;
                    end else begin
                        held_rpm_next = (|div_quot[DIV_STEPS-1:40]) ? '1 : div_quot[39:0];
                        last_ms_next  = now_reg;
                        status_next   = STATUS_UPDATED;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {held_rpm_reg, held_freq_reg};
                    out_user_next  = status_reg;
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            clock_hz_reg     <= 30'd84000000;
            prescale_reg     <= 17'd1;
            reload_reg       <= 32'd65535;
            ppr_reg          <= 16'd1;
            timeout_reg      <= 32'd1000;
            min_interval_reg <= 16'd20;
            prev_reg         <= '0;
            last_ms_reg      <= '0;
            held_freq_reg    <= '0;
            held_rpm_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            prev_reg      <= prev_next;
            last_ms_reg   <= last_ms_next;
            held_freq_reg <= held_freq_next;
            held_rpm_reg  <= held_rpm_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TIMER_CLOCK_HZ:   clock_hz_reg     <= cfg_data[29:0];
                    CFG_PRESCALE_DIVISOR: prescale_reg     <= cfg_data[16:0];
                    CFG_RELOAD_VALUE:     reload_reg       <= cfg_data;
                    CFG_PULSES_PER_REV:   ppr_reg          <= cfg_data[15:0];
                    CFG_TIMEOUT_MS:       timeout_reg      <= cfg_data;
                    CFG_MIN_INTERVAL:     min_interval_reg <= cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg <= s_tuser;
            cap_reg  <= s_tdata[31:0];
            now_reg  <= s_tdata[63:32];
        end
        diff_reg     <= diff_next;
        status_reg   <= status_next;
        acc_reg      <= acc_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        den1_reg     <= den1_next;
        den2_reg     <= den2_next;
        num_reg      <= num_next;
        quot_reg     <= quot_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    // The sequencer works on one item at a time.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input accepted while a transaction was still in work");

    // A timeout result always reports zero speed.
    a_timeout_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STATUS_TIMED_OUT) |-> (m_tdata == 72'd0))
        else $error("timed-out result carries a nonzero speed");

    // The multiply passes never run past their multiplier width.
    a_mul_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL1 || state_reg == ST_MUL2)
            |-> (cnt_reg < CNT_WIDTH'(MUL_STEPS)))
        else $error("multiply step counter out of range");

endmodule

`default_nettype wire
